// File: rtl/mbrtu_pkg.sv
// Package with shared types and constants for the Modbus RTU slave frame engine.
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_item_t;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [7:0]  BcastAddr = 8'd255;
  localparam logic [7:0]  ExcIllegalFunc = 8'h01;
  localparam logic [7:0]  ExcIllegalAddr = 8'h02;
  localparam logic [7:0]  FnReadHolding = 8'd3;
  localparam logic [7:0]  FnReadInput = 8'd4;
  localparam logic [7:0]  FnWriteSingle = 8'd6;
  localparam logic        FuncByte = 1'b0;

  // Handshake between the sequencer and the bit-serial CRC unit.
  typedef struct packed {
    logic       load;
    logic       init;
    logic [7:0] data;
  } crc_cmd_t;

endpackage
`default_nettype wire

// File: rtl/mbrtu_crc.sv
// Bit-serial CRC-16/MODBUS unit that folds in one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_crc
  import mbrtu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire crc_cmd_t    cmd_i,
  output logic             busy_o,
  output logic [15:0]      crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] seed;

  // Start from the init value or the running value, then shift eight times; init alone resets.
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    seed  = cmd_i.init ? CrcInit : crc_q;
    if (cmd_i.load) begin
      crc_d = seed ^ {8'h00, cmd_i.data};
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);
      cnt_d = cnt_q - 4'd1;
    end else if (cmd_i.init) begin
      crc_d = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign busy_o = (cnt_q != 4'd0);
  assign crc_o  = crc_q;

endmodule
`default_nettype wire

// File: rtl/modbus_rtu_slave_frame_engine.sv
// Top level of the Modbus RTU slave frame engine: receiver, sequencer and register table.
// A received byte holds the input for a load and eight bit steps of the shared CRC unit
// and a return to idle; the first two bytes start no CRC work. A frame end without a
// reply goes from check to idle. A reply passes check and plan, folds each byte before
// its CRC, reads registers in request and wait states, sends the CRC; stalls can delay it.
// Reset is asynchronous, active low; the table is then cleared by a sweep of all entries.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_frame_engine
  import mbrtu_pkg::*;
#(
  parameter int TABLE_SIZE     = 64,
  parameter int MAX_READ_WORDS = 16,
  parameter int MAX_FRAME      = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_RXCRC  = 11'b00000000100,
    S_CHECK  = 11'b00000001000,
    S_PLAN   = 11'b00000010000,
    S_RDREQ  = 11'b00000100000,
    S_RDWAIT = 11'b00001000000,
    S_EMIT   = 11'b00010000000,
    S_FOLD   = 11'b00100000000,
    S_CRCLO  = 11'b01000000000,
    S_CRCHI  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]  slave_addr_q;
  logic [7:0]  head_q [6];
  logic [7:0]  tail_q [2];
  logic [8:0]  cnt_q;
  logic [15:0] mem [TABLE_SIZE];
  logic [15:0] rd_q;
  logic [AW-1:0] clr_q;

  // Reply bookkeeping.
  logic [5:0]  idx_q;      // reply byte index
  logic [5:0]  len_q;      // reply length before CRC
  logic [1:0]  kind_q;     // 0 read, 1 echo, 2 exception
  logic [7:0]  code_q;
  logic [12:0] raddr_q;
  logic        wr_en;

  out_item_t   out_q;
  logic        out_v_q;

  crc_cmd_t    crc_cmd;
  logic        crc_busy;
  logic [15:0] crc_val;

  mbrtu_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .busy_o (crc_busy),
    .crc_o  (crc_val)
  );

  logic [15:0] a_w, c_w;
  logic [16:0] sum_w;
  logic        frame_ok;
  logic        in_acc, out_acc;
  logic [7:0]  cur_byte;

  assign a_w   = {head_q[2], head_q[3]};
  assign c_w   = {head_q[4], head_q[5]};
  assign sum_w = {1'b0, a_w} + {1'b0, c_w};
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_v_q && !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  assign frame_ok = (head_q[0] != 8'd0) && (cnt_q > 9'd5) &&
                    ((head_q[0] == slave_addr_q) || (head_q[0] == BcastAddr)) &&
                    (tail_q[0] == crc_val[7:0]) && (tail_q[1] == crc_val[15:8]);

  // Reply byte at the current index.
  always_comb begin
    cur_byte = 8'h00;
    if (idx_q == 6'd0) begin
      cur_byte = head_q[0];
    end else if (idx_q == 6'd1) begin
      cur_byte = (kind_q == 2'd2) ? (head_q[1] | 8'h80) : head_q[1];
    end else if (kind_q == 2'd2) begin
      cur_byte = code_q;
    end else if (kind_q == 2'd1) begin
      cur_byte = head_q[idx_q[2:0]];
    end else if (idx_q == 6'd2) begin
      cur_byte = {c_w[6:0], 1'b0};
    end else begin
      cur_byte = idx_q[0] ? rd_q[15:8] : rd_q[7:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    crc_cmd = '0;
    wr_en   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(TABLE_SIZE - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.func == FuncByte) begin
            if (cnt_q >= 9'd2 && cnt_q < 9'(MAX_FRAME)) begin
              crc_cmd.load = 1'b1;
              crc_cmd.data = tail_q[0];
              state_d = S_RXCRC;
            end
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_RXCRC: begin
        if (!crc_busy) state_d = S_IDLE;
      end
      S_CHECK: begin
        // The running CRC starts over for the next frame, good or bad.
        crc_cmd.init = 1'b1;
        state_d = frame_ok ? S_PLAN : S_IDLE;
      end
      S_PLAN: begin
        if (kind_q == 2'd1) wr_en = 1'b1;
        state_d = S_EMIT;
      end
      S_RDREQ: state_d = S_RDWAIT;
      S_RDWAIT: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_v_q || out_acc) begin
          crc_cmd.load = 1'b1;
          crc_cmd.init = (idx_q == 6'd0);
          crc_cmd.data = cur_byte;
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if (!crc_busy) begin
          if (idx_q == len_q) state_d = S_CRCLO;
          else if (kind_q == 2'd0 && idx_q >= 6'd3 && idx_q[0]) state_d = S_RDREQ;
          else state_d = S_EMIT;
        end
      end
      S_CRCLO: if (!out_v_q || out_acc) state_d = S_CRCHI;
      S_CRCHI: if (!out_v_q || out_acc) begin
        crc_cmd.init = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Register table: clearing sweep, one write port, registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) mem[clr_q] <= 16'h0000;
    else if (wr_en) mem[a_w[AW-1:0]] <= c_w;
    rd_q <= mem[raddr_q[AW-1:0]];
  end

  // Control and receive registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      slave_addr_q <= 8'd1;
      clr_q        <= '0;
      cnt_q        <= '0;
      for (int i = 0; i < 6; i++) head_q[i] <= '0;
      tail_q[0]    <= '0;
      tail_q[1]    <= '0;
      idx_q        <= '0;
      len_q        <= '0;
      kind_q       <= '0;
      code_q       <= '0;
      raddr_q      <= '0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) slave_addr_q <= cfg_data_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (out_acc) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_item_i.func == FuncByte && cnt_q < 9'(MAX_FRAME)) begin
            if (cnt_q < 9'd6) head_q[cnt_q[2:0]] <= in_item_i.rx_byte;
            tail_q[0] <= tail_q[1];
            tail_q[1] <= in_item_i.rx_byte;
            cnt_q     <= cnt_q + 9'd1;
          end
        end
        S_CHECK: begin
          idx_q   <= '0;
          raddr_q <= a_w[12:0];
          code_q  <= '0;
          if (head_q[1] == FnReadHolding || head_q[1] == FnReadInput) begin
            if (sum_w <= 17'(TABLE_SIZE) && c_w <= 16'(MAX_READ_WORDS)) begin
              kind_q <= 2'd0;
              len_q  <= 6'd3 + {c_w[4:0], 1'b0};
            end else begin
              kind_q <= 2'd2; code_q <= ExcIllegalAddr; len_q <= 6'd3;
            end
          end else if (head_q[1] == FnWriteSingle) begin
            if (a_w < 16'(TABLE_SIZE)) begin
              kind_q <= 2'd1;
              len_q  <= (cnt_q < 9'd8) ? 6'(cnt_q - 9'd2) : 6'd6;
            end else begin
              kind_q <= 2'd2; code_q <= ExcIllegalAddr; len_q <= 6'd3;
            end
          end else begin
            kind_q <= 2'd2; code_q <= ExcIllegalFunc; len_q <= 6'd3;
          end
          tail_q[0] <= '0;
          tail_q[1] <= '0;
          cnt_q     <= '0;
        end
        S_EMIT: begin
          if (!out_v_q || out_acc) begin
            out_v_q <= 1'b1;
            out_q   <= '{tx_byte: cur_byte, tx_last: 1'b0};
            idx_q   <= idx_q + 6'd1;
            // Move to the next register once the low byte of this one is out.
            if (kind_q == 2'd0 && idx_q >= 6'd4 && !idx_q[0]) raddr_q <= raddr_q + 13'd1;
          end
        end
        S_CRCLO: if (!out_v_q || out_acc) begin
          out_v_q <= 1'b1;
          out_q   <= '{tx_byte: crc_val[7:0], tx_last: 1'b0};
        end
        S_CRCHI: if (!out_v_q || out_acc) begin
          out_v_q <= 1'b1;
          out_q   <= '{tx_byte: crc_val[15:8], tx_last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  // After the check state of a frame end, the receiver must be cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |=> (cnt_q == 9'd0))
    else $error("receiver not cleared at frame end");

  // No item is taken in the emit and CRC high byte states of a reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_CRCHI) |-> in_stall_o)
    else $error("input accepted during reply");

  // The last byte of a reply is only ever the CRC high byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q && out_q.tx_last) |-> $past(state_q == S_CRCHI))
    else $error("tx_last outside CRC high byte");

endmodule
`default_nettype wire
